@@ design/sb64_pkg.sv @@
// Shared constants, types and functions for the SHA-1 base64 digest block.
`timescale 1ns / 1ps
package sb64_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned NumChars   = 28;
  localparam int unsigned LenBits    = 61;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [6:0]  PadChar = 7'h3D;

  // round unit request
  typedef struct packed {
    logic start;
  } rnd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    begin
      if (v < 6'd26) c = 7'(7'd65 + 7'(v));
      else if (v < 6'd52) c = 7'(7'd71 + 7'(v));
      else if (v < 6'd62) c = 7'(7'(v) - 7'd4);
      else if (v == 6'd62) c = 7'h2B;
      else c = 7'h2F;
      return c;
    end
  endfunction
endpackage

@@ design/sb64_round.sv @@
// SHA-1 compression: one round per cycle for 80 rounds, chain update at end.
`timescale 1ns / 1ps
module sb64_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sb64_pkg::rnd_req_t   req,
  input  logic                 clr_chain,
  input  logic                 wr_en,
  input  logic [3:0]           wr_idx,
  input  logic [31:0]          wr_data,
  output sb64_pkg::rnd_sts_t   sts,
  output logic [159:0]         chain
);
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [6:0]  rnd_r;
  logic        busy_r, fin_r;
  logic [3:0]  s;
  logic [31:0] wx, wn, f, k, t;

  assign s  = rnd_r[3:0];
  assign wx = w_r[4'(s + 4'd13)] ^ w_r[4'(s + 4'd8)] ^ w_r[4'(s + 4'd2)] ^ w_r[s];

  always_comb begin
    wn = (rnd_r >= 7'd16) ? {wx[30:0], wx[31]} : w_r[s];
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = sb64_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = sb64_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = sb64_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = sb64_pkg::K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + wn;
  end

  always_ff @(posedge clk) begin
    if (wr_en) w_r[wr_idx] <= wr_data;
    else if (busy_r) w_r[s] <= wn;
    if (req.start) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
    end else if (busy_r) begin
      e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; fin_r <= 1'b0; rnd_r <= '0;
      h_r[0] <= sb64_pkg::H0; h_r[1] <= sb64_pkg::H1; h_r[2] <= sb64_pkg::H2;
      h_r[3] <= sb64_pkg::H3; h_r[4] <= sb64_pkg::H4;
    end else begin
      fin_r <= 1'b0;
      if (clr_chain) begin
        h_r[0] <= sb64_pkg::H0; h_r[1] <= sb64_pkg::H1; h_r[2] <= sb64_pkg::H2;
        h_r[3] <= sb64_pkg::H3; h_r[4] <= sb64_pkg::H4;
      end else if (fin_r) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
      end
      if (req.start) begin
        busy_r <= 1'b1; rnd_r <= '0;
      end else if (busy_r) begin
        rnd_r <= 7'(rnd_r + 7'd1);
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0; fin_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r | fin_r;
  assign sts.done = fin_r;
  assign chain = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
endmodule

@@ design/sha1_base64_digest.sv @@
// Top level: byte intake, padding sequencer and base64 output.
`timescale 1ns / 1ps
// SHA-1 digest of a byte stream, returned as 28 base64 characters.
// Input channel: in_valid/in_stall with in_data_byte and in_last_byte, one
// message byte per beat; in_last_byte marks the final byte.
// Output channel: out_valid/out_stall with out_b64_char and out_last_char;
// 28 beats per message, the last one '=' with out_last_char high.
// A byte that does not close a block is taken in the cycle it is offered. A byte
// that fills a block holds in_stall while the shared round unit runs 80 rounds,
// one per cycle, and then updates the chaining words. After the last byte,
// padding adds one byte per cycle while the round unit is idle, plus one or two
// more compressions, then 28 characters stream out, one per cycle while
// out_stall is low, followed by a state that restores the chaining words.
// Sustained rate is set by the single round unit: no byte is taken while it
// compresses a block.
// A stalled output holds its character; no new byte is taken until the whole
// digest has been delivered. Reset (rst_n low, synchronous) restores the
// initial chaining words and clears the byte count and fill.
module sha1_base64_digest (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_b64_char,
  output logic       out_last_char
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_HASH = 6'b000010, S_PAD = 6'b000100,
    S_PHASH = 6'b001000, S_OUT = 6'b010000, S_CLR = 6'b100000
  } st_t;

  st_t st_r, st_nxt;
  logic [5:0]  fill_r;
  logic [60:0] len_r;
  logic [31:0] word_r;
  logic        pad_r, lastblk_r, tail_r, end_r;
  logic [4:0]  cnt_r;
  logic [167:0] dig_r;
  sb64_pkg::rnd_req_t req;
  sb64_pkg::rnd_sts_t sts;
  logic [159:0] chain;
  logic        wr_en, put, acc;
  logic [7:0]  pbyte;
  logic [31:0] wnew;
  logic [63:0] bits;

  sb64_round u_round (.clk(clk), .rst_n(rst_n), .req(req), .clr_chain(st_r == S_CLR),
    .wr_en(wr_en), .wr_idx(fill_r[5:2]), .wr_data(wnew), .sts(sts), .chain(chain));

  assign acc = (st_r == S_IDLE) && in_valid;
  assign in_stall = (st_r != S_IDLE);
  assign bits = {len_r, 3'b000};

  always_comb begin
    pbyte = 8'h00;
    if (!pad_r) pbyte = sb64_pkg::PadByte;
    else if (tail_r) pbyte = bits[6'(6'd63 - {fill_r[2:0], 3'b000}) -: 8];
  end

  assign put = acc || (st_r == S_PAD && !sts.busy);
  always_comb begin
    wnew = (fill_r[1:0] == 2'd0) ? 32'd0 : word_r;
    wnew[5'(5'd31 - {fill_r[1:0], 3'b000}) -: 8] = acc ? in_data_byte : pbyte;
  end
  assign wr_en = put;
  assign req.start = put && (fill_r == 6'd63);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid)
        st_nxt = (fill_r == 6'd63) ? S_HASH : (in_last_byte ? S_PAD : S_IDLE);
      S_HASH: if (sts.done) st_nxt = end_r ? S_PAD : S_IDLE;
      S_PAD:  if (!sts.busy && fill_r == 6'd63) st_nxt = S_PHASH;
      // wait for the chain update before taking the digest
      S_PHASH: if (!sts.busy) st_nxt = lastblk_r ? S_OUT : S_PAD;
      S_OUT:  if (!out_stall && cnt_r == 5'd27) st_nxt = S_CLR;
      S_CLR:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (put) word_r <= wnew;
    if (st_r == S_PHASH && !sts.busy) dig_r <= {chain, 8'h00};
    else if (st_r == S_OUT && !out_stall) dig_r <= {dig_r[161:0], 6'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fill_r <= '0; len_r <= '0; pad_r <= 1'b0;
      lastblk_r <= 1'b0; tail_r <= 1'b0; end_r <= 1'b0; cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (acc) len_r <= 61'(len_r + 61'd1);
      if (put) begin
        fill_r <= 6'(fill_r + 6'd1);
        if (!acc) begin
          if (!pad_r) pad_r <= 1'b1;
          // length goes in the last 8 bytes of the block where it fits
          if (!pad_r ? (fill_r < 6'd56) : 1'b1) begin
            if (6'(fill_r + 6'd1) == 6'd56 && !(!pad_r && fill_r == 6'd55 && 1'b0))
              tail_r <= 1'b1;
          end
          if (fill_r == 6'd63 && tail_r) lastblk_r <= 1'b1;
        end
      end
      if (acc && in_last_byte) begin
        pad_r <= 1'b0; tail_r <= 1'b0; lastblk_r <= 1'b0; end_r <= 1'b1;
      end
      if (st_r == S_OUT && !out_stall) cnt_r <= 5'(cnt_r + 5'd1);
      if (st_r == S_CLR) begin
        len_r <= '0; fill_r <= '0; cnt_r <= '0; pad_r <= 1'b0;
        tail_r <= 1'b0; lastblk_r <= 1'b0; end_r <= 1'b0;
      end
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_last_char = (cnt_r == 5'd27);
  assign out_b64_char = out_last_char ? sb64_pkg::PadChar
                                      : sb64_pkg::b64_char(dig_r[167:162]);
endmodule
